// ===== hw/rtl/cpr_pkg.sv =====
// Shared constants, defaults and sequencer state type for the clock page replacement block.
package cpr_pkg;

  localparam int MAX_FRAMES_DEFAULT = 64;
  localparam int PAGE_BITS_DEFAULT  = 8;

  localparam int FRAME_COUNT_W = 7;
  localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 7'd4;

  localparam int FRAME_INDEX_W = 6;
  localparam int FAULT_W       = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SWEEP,
    ST_EVICT,
    ST_FINISH
  } cpr_state_t;

endpackage

// ===== hw/rtl/clock_page_replacement.sv =====
// Clock (second-chance) page replacement: frame table, lookup scan, hand sweep and result register.
// Page zero goes from the input transfer straight to the finish step; a hit in frame k runs the
// lookup scan up to frame k, then the finish step; a fault runs the lookup scan over the N frames
// in use, the hand sweep, the evict step and the finish step. One item is worked at a time, set
// by the single table read port and the one-frame-per-cycle sweep; the next transfer is taken the
// cycle after the result loads. Synchronous reset empties every frame and the control state.
module clock_page_replacement
  import cpr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEFAULT,
  parameter int PAGE_BITS  = PAGE_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_enable,
  input  logic [FRAME_COUNT_W-1:0] cfg_write_data,
  input  logic                     page_valid,
  output logic                     page_stall,
  input  logic [PAGE_BITS-1:0]     page_number,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic                     hit,
  output logic [FRAME_INDEX_W-1:0] frame_index,
  output logic [PAGE_BITS-1:0]     evicted_page,
  output logic [FAULT_W-1:0]       fault_total
);

  // Index width addresses one frame; count width also holds the frame count itself.
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W = (CNT_W > FRAME_COUNT_W) ? CNT_W : FRAME_COUNT_W;

  cpr_state_t state, state_next;

  // Configuration and replacement state.
  logic [FRAME_COUNT_W-1:0] frame_count;
  logic [IDX_W-1:0]         clock_hand;
  logic [FAULT_W-1:0]       fault_counter;
  logic [MAX_FRAMES-1:0]    ref_bit;
  // A frame whose bit here is clear has never been filled and reads as the empty page.
  logic [MAX_FRAMES-1:0]    slot_used;

  // The frame table is a memory with one registered read port and one write port.
  logic [PAGE_BITS-1:0] frame_page [MAX_FRAMES];
  logic [IDX_W-1:0]     rd_addr;
  logic [PAGE_BITS-1:0] rd_data;
  logic                 rd_used;

  // Working registers of the item in flight.
  logic [PAGE_BITS-1:0] page;
  logic [CNT_W-1:0]     scan;
  logic [IDX_W-1:0]     probe;
  logic                 probe_live;
  logic [IDX_W-1:0]     sweep_hand;
  logic                 res_hit;
  logic [IDX_W-1:0]     res_where;
  logic [PAGE_BITS-1:0] res_evicted;

  logic [CNT_W-1:0] frames_n;
  logic [CMP_W-1:0] fc_ext;
  logic [CMP_W-1:0] max_ext;
  logic             accept;
  logic             out_free;
  logic             search_match;
  logic             search_miss;
  logic             sweep_found;
  logic [IDX_W-1:0] hand_start;
  logic [CNT_W-1:0] hand_inc;
  logic [IDX_W-1:0] hand_wrap;

  // Frames in use: zero acts as one, and anything above the table size acts as the table size.
  always_comb begin
    fc_ext  = CMP_W'(frame_count);
    max_ext = CMP_W'(MAX_FRAMES);
    if (fc_ext == '0) begin
      frames_n = CNT_W'(1);
    end else if (fc_ext > max_ext) begin
      frames_n = CNT_W'(MAX_FRAMES);
    end else begin
      frames_n = CNT_W'(fc_ext);
    end
  end

  // The sweep starts at frame zero when the hand lies beyond a shrunken frame count.
  assign hand_start = (CNT_W'(clock_hand) >= frames_n) ? '0 : clock_hand;
  // Advance the sweep hand by one with wrap at the frame count.
  assign hand_inc   = CNT_W'(sweep_hand) + CNT_W'(1);
  assign hand_wrap  = (hand_inc >= frames_n) ? '0 : hand_inc[IDX_W-1:0];

  assign accept   = page_valid && !page_stall;
  assign out_free = !result_valid || !result_stall;

  // Lookup: the data of frame probe arrives in the cycle after its read was issued.
  assign search_match = probe_live && rd_used && (rd_data == page);
  assign search_miss  = !probe_live && (scan == frames_n);
  assign sweep_found  = !ref_bit[sweep_hand];

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (page_valid) begin
          state_next = (page_number == '0) ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (search_match) begin
          state_next = ST_FINISH;
        end else if (search_miss) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sweep_found) begin
          state_next = ST_EVICT;
        end
      end
      ST_EVICT:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: input stall and the frame table read address.
  always_comb begin
    page_stall = 1'b1;
    rd_addr    = sweep_hand;
    case (state)
      ST_IDLE:   page_stall = 1'b0;
      ST_SEARCH: rd_addr = scan[IDX_W-1:0];
      ST_SWEEP:  rd_addr = sweep_hand;
      ST_EVICT:  rd_addr = sweep_hand;
      ST_FINISH: rd_addr = sweep_hand;
      default:   page_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Frame table memory: one registered read and one write per cycle.
  always_ff @(posedge clk) begin
    rd_data <= frame_page[rd_addr];
    if (state == ST_EVICT) begin
      frame_page[sweep_hand] <= page;
    end
  end

  // Control state that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= FRAME_COUNT_RESET;
      clock_hand    <= '0;
      fault_counter <= '0;
      ref_bit       <= '0;
      slot_used     <= '0;
      probe_live    <= 1'b0;
      result_valid  <= 1'b0;
      rd_used       <= 1'b0;
    end else begin
      rd_used <= slot_used[rd_addr];
      if (cfg_write_enable) begin
        frame_count <= cfg_write_data;
      end
      // The result register fills when the finish step hands over and empties on a transfer.
      if ((state == ST_FINISH) && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          probe_live <= 1'b0;
        end
        ST_SEARCH: begin
          if (search_match) begin
            // Second chance granted: mark the resident frame as recently used.
            ref_bit[probe] <= 1'b1;
          end else begin
            probe_live <= (scan < frames_n);
          end
        end
        ST_SWEEP: begin
          if (!sweep_found) begin
            ref_bit[sweep_hand] <= 1'b0;
          end
        end
        ST_EVICT: begin
          ref_bit[sweep_hand]   <= 1'b1;
          slot_used[sweep_hand] <= 1'b1;
          clock_hand            <= hand_wrap;
          if (fault_counter != '1) begin
            fault_counter <= fault_counter + FAULT_W'(1);
          end
        end
        ST_FINISH: begin
          probe_live <= 1'b0;
        end
        default: begin
          probe_live <= 1'b0;
        end
      endcase
    end
  end

  // Payload and working registers; they need no reset.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          page        <= page_number;
          scan        <= '0;
          sweep_hand  <= hand_start;
          // A reference to the empty marker reports the current hand and changes nothing.
          res_hit     <= 1'b0;
          res_where   <= clock_hand;
          res_evicted <= '0;
        end
      end
      ST_SEARCH: begin
        if (search_match) begin
          res_hit   <= 1'b1;
          res_where <= probe;
        end else if (scan < frames_n) begin
          probe <= scan[IDX_W-1:0];
          scan  <= scan + CNT_W'(1);
        end
      end
      ST_SWEEP: begin
        if (!sweep_found) begin
          sweep_hand <= hand_wrap;
        end
      end
      ST_EVICT: begin
        res_where   <= sweep_hand;
        res_evicted <= rd_used ? rd_data : '0;
      end
      ST_FINISH: begin
        if (out_free) begin
          hit          <= res_hit;
          frame_index  <= FRAME_INDEX_W'(res_where);
          evicted_page <= res_evicted;
          fault_total  <= fault_counter;
        end
      end
      default: begin
        scan <= '0;
      end
    endcase
  end

  // A result only appears after the sequencer has finished an item.
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_FINISH))
    else $error("result appeared without a finished item");

  // The fault count never goes backward outside reset.
  a_fault_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> fault_counter >= $past(fault_counter))
    else $error("fault count decreased");

  // The sweep hand stays inside the frames in use.
  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (CNT_W'(sweep_hand) < frames_n))
    else $error("sweep hand beyond frame count");

  // The victim frame always has its reference bit clear.
  a_victim_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVICT) |-> !ref_bit[sweep_hand])
    else $error("evicting a frame with its reference bit set");

endmodule
